@@ design/psd_pkg.sv @@
// Package for the pressure start detector.
// Holds field widths, configuration register indexes and shared structs.
// No dependencies; every other file depends on it.
package psd_pkg;

    // Fixed field widths of the channels.
    localparam int PRESSURE_W = 16;
    localparam int THR_W      = 15;
    localparam int LIMIT_W    = 8;
    localparam int AMOUNT_W   = 15;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_MODE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_THRESHOLD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_LIMIT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD  = 8'd3;

    // Reset values of the configuration registers.
    localparam logic               RST_DETECT_MODE     = 1'b0;
    localparam logic [THR_W-1:0]   RST_SPEED_THRESHOLD = 15'd4;
    localparam logic [LIMIT_W-1:0] RST_CONFIRM_LIMIT   = 8'd3;
    localparam logic [THR_W-1:0]   RST_DROP_THRESHOLD  = 15'd40;

    // Detection modes.
    localparam logic MODE_DROP  = 1'b0;
    localparam logic MODE_SPEED = 1'b1;

    // Item function codes.
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_REARM  = 1'b1;

    // Saturation limit of the reported amount.
    localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = 15'h7fff;

    // Current configuration as seen by the detector.
    typedef struct packed {
        logic               detect_mode;
        logic [THR_W-1:0]   speed_threshold;
        logic [LIMIT_W-1:0] confirm_limit;
        logic [THR_W-1:0]   drop_threshold;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic                started;
        logic                fired_now;
        logic [AMOUNT_W-1:0] trigger_amount;
    } res_t;

endpackage

@@ design/psd_intf.sv @@
// Channel interfaces of the pressure start detector: samples, results and
// configuration writes, each with a valid/ready handshake.
// Depends on psd_pkg.
interface psd_in_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [psd_pkg::PRESSURE_W-1:0]   pressure;

    modport source (output valid, output func, output pressure, input ready);
    modport sink   (input valid, input func, input pressure, output ready);
endinterface

interface psd_out_if;
    logic                             valid;
    logic                             ready;
    logic                             started;
    logic                             fired_now;
    logic [psd_pkg::AMOUNT_W-1:0]     trigger_amount;

    modport source (output valid, output started, output fired_now,
                    output trigger_amount, input ready);
    modport sink   (input valid, input started, input fired_now,
                    input trigger_amount, output ready);
endinterface

interface psd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [psd_pkg::CFG_IDX_W-1:0]    index;
    logic [psd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/psd_cfg_regs.sv @@
// Configuration register file of the pressure start detector.
// Decodes register writes and holds the four settings.
// Depends on psd_pkg.
module psd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [psd_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]   wr_data,
    output psd_pkg::cfg_t                    cfg
);
    import psd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode; unknown indexes leave the registers unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_DETECT_MODE:     cfg_next.detect_mode     = wr_data[0];
                REG_SPEED_THRESHOLD: cfg_next.speed_threshold = wr_data[THR_W-1:0];
                REG_CONFIRM_LIMIT:   cfg_next.confirm_limit   = wr_data[LIMIT_W-1:0];
                REG_DROP_THRESHOLD:  cfg_next.drop_threshold  = wr_data[THR_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_mode     <= RST_DETECT_MODE;
            cfg_reg.speed_threshold <= RST_SPEED_THRESHOLD;
            cfg_reg.confirm_limit   <= RST_CONFIRM_LIMIT;
            cfg_reg.drop_threshold  <= RST_DROP_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/psd_core.sv @@
// Detection core of the pressure start detector.
// Holds the tracking state and computes one result per stepped item.
// Depends on psd_pkg.
module psd_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             func,
    input  logic [psd_pkg::PRESSURE_W-1:0]   pressure,
    input  psd_pkg::cfg_t                    cfg,
    output psd_pkg::res_t                    res
);
    import psd_pkg::*;

    // Comparison width: holds a signed sample difference and a threshold.
    localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [SAMPLE_BITS-1:0] base_reg, base_next;
    logic [LIMIT_W-1:0]     count_reg, count_next;
    logic                   seeded_reg, seeded_next;
    logic                   latched_reg, latched_next;

    logic [SAMPLE_BITS-1:0] smp;
    logic [SAMPLE_BITS-1:0] delta;
    logic [SAMPLE_BITS-1:0] diff_base;
    logic [CMP_W-1:0]       delta_ext;
    logic [CMP_W-1:0]       drop_ext;
    logic [CMP_W-1:0]       speed_thr_ext;
    logic [CMP_W-1:0]       drop_thr_ext;
    logic                   speed_hit;
    logic                   drop_hit;
    logic                   below_base;
    logic [LIMIT_W-1:0]     count_inc;
    logic [AMOUNT_W-1:0]    delta_sat;
    logic [AMOUNT_W-1:0]    drop_sat;

    // Fit the pressure field to the sample width.
    generate
        if (SAMPLE_BITS > PRESSURE_W)
        begin : g_widen
            assign smp = {{(SAMPLE_BITS-PRESSURE_W){1'b0}}, pressure};
        end
        else if (SAMPLE_BITS == PRESSURE_W)
        begin : g_same
            assign smp = pressure;
        end
        else
        begin : g_narrow
            assign smp = pressure[SAMPLE_BITS-1:0];
        end
    endgenerate

    // Wrapping differences and their threshold compares.
    assign delta         = smp - prev_reg;
    assign diff_base     = smp - base_reg;
    assign below_base    = diff_base[SAMPLE_BITS-1];
    assign delta_ext     = {{(CMP_W-SAMPLE_BITS){delta[SAMPLE_BITS-1]}}, delta};
    assign drop_ext      = below_base ? '0
                         : {{(CMP_W-SAMPLE_BITS){1'b0}}, diff_base};
    assign speed_thr_ext = {{(CMP_W-THR_W){1'b0}}, cfg.speed_threshold};
    assign drop_thr_ext  = {{(CMP_W-THR_W){1'b0}}, cfg.drop_threshold};
    assign speed_hit     = $signed(delta_ext) > $signed(speed_thr_ext);
    assign drop_hit      = $signed(drop_ext) > $signed(drop_thr_ext);
    assign count_inc     = count_reg + LIMIT_W'(1);

    // Saturate the amounts; both are non-negative whenever they are reported.
    assign delta_sat = (delta_ext[CMP_W-1:AMOUNT_W] != '0) ? AMOUNT_MAX
                     : delta_ext[AMOUNT_W-1:0];
    assign drop_sat  = (drop_ext[CMP_W-1:AMOUNT_W] != '0) ? AMOUNT_MAX
                     : drop_ext[AMOUNT_W-1:0];

    // Next state and result for the current item.
    always_comb
    begin
        prev_next         = prev_reg;
        base_next         = base_reg;
        count_next        = count_reg;
        seeded_next       = seeded_reg;
        latched_next      = latched_reg;
        res.fired_now     = 1'b0;
        res.trigger_amount = '0;

        if (func == FUNC_REARM)
        begin
            prev_next    = '0;
            base_next    = '0;
            count_next   = '0;
            seeded_next  = 1'b0;
            latched_next = 1'b0;
        end
        else if (!latched_reg && (smp != '0))
        begin
            if (cfg.detect_mode == MODE_SPEED)
            begin
                prev_next = smp;
                if (prev_reg != '0)
                begin
                    if (speed_hit)
                    begin
                        count_next = count_inc;
                        if (count_inc >= cfg.confirm_limit)
                        begin
                            latched_next       = 1'b1;
                            res.fired_now      = 1'b1;
                            res.trigger_amount = delta_sat;
                        end
                    end
                    else
                    begin
                        count_next = '0;
                    end
                end
            end
            else
            begin
                if (!seeded_reg)
                begin
                    base_next   = smp;
                    seeded_next = 1'b1;
                end
                else
                begin
                    if (below_base)
                    begin
                        base_next = smp;
                    end
                    if (drop_hit)
                    begin
                        latched_next       = 1'b1;
                        res.fired_now      = 1'b1;
                        res.trigger_amount = drop_sat;
                    end
                end
            end
        end
        res.started = latched_next;
    end

    // Tracking state advances once per stepped item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            base_reg    <= '0;
            count_reg   <= '0;
            seeded_reg  <= 1'b0;
            latched_reg <= 1'b0;
        end
        else if (step)
        begin
            prev_reg    <= prev_next;
            base_reg    <= base_next;
            count_reg   <= count_next;
            seeded_reg  <= seeded_next;
            latched_reg <= latched_next;
        end
    end

endmodule

@@ design/pressure_start_detector.sv @@
// Top level of the pressure start detector.
// Instantiates psd_cfg_regs and psd_core; uses psd_pkg and the psd_*_if channels.
//
// Usage:
//   sample : sink channel; each transfer is a pressure sample (func = 0) or a
//            rearm command (func = 1) that clears all tracking state.
//   result : source channel; exactly one transfer per sample transfer, in
//            order, carrying started, fired_now and trigger_amount.
//   cfg    : register write channel, always ready; write only while idle.
//            Index 0 detect_mode, 1 speed_threshold, 2 confirm_limit,
//            3 drop_threshold.
// A sample transfer goes first into the input register, then through the
// detection logic into the result register, where the tracking state
// updates. Throughput is one item per cycle while the result channel is
// not stalled.
// A stalled result holds its register; the input register still takes one
// more item, and sample.ready drops only when both registers are full.
// Reset clears the tracking state, empties both registers and loads the
// configuration defaults (drop mode, thresholds 4 and 40, limit 3).
module pressure_start_detector #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    psd_in_if.sink     sample,
    psd_out_if.source  result,
    psd_cfg_if.sink    cfg
);
    import psd_pkg::*;

    logic                  in_valid_reg, in_valid_next;
    logic                  in_func_reg;
    logic [PRESSURE_W-1:0] in_pressure_reg;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg;
    res_t                  core_res;
    cfg_t                  cfg_cur;
    logic                  out_free;
    logic                  step;
    logic                  in_take;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    psd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_cur)
    );

    // Handshake control of the two registers.
    assign out_free      = !out_valid_reg || result.ready;
    assign step          = in_valid_reg && out_free;
    assign sample.ready  = !in_valid_reg || out_free;
    assign in_take       = sample.valid && sample.ready;
    assign in_valid_next = in_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg     <= sample.func;
            in_pressure_reg <= sample.pressure;
        end
    end

    // Detection logic and tracking state.
    psd_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .func     (in_func_reg),
        .pressure (in_pressure_reg),
        .cfg      (cfg_cur),
        .res      (core_res)
    );

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= core_res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.started        = out_reg.started;
    assign result.fired_now      = out_reg.fired_now;
    assign result.trigger_amount = out_reg.trigger_amount;

endmodule

@@ verif/tb.sv @@
// Testbench for the pressure start detector: directed and random sample streams in
// both detection modes, with register writes between phases and random idling.
// Depends on psd_pkg, the psd_*_if channel interfaces and pressure_start_detector.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psd_pkg::*;

    localparam int REG_COUNT = 4;
    localparam int ITEM_TOTAL = 1850;

    // Tracks detector state from accepted transfers and holds the results still owed.
    class start_tracker;
        logic                  mode;
        logic [THR_W-1:0]      speed_thr;
        logic [LIMIT_W-1:0]    confirm_lim;
        logic [THR_W-1:0]      drop_thr;
        logic [PRESSURE_W-1:0] last_sample;
        logic [PRESSURE_W-1:0] floor_sample;
        logic [7:0]            run_count;
        logic                  floor_valid;
        logic                  start_latched;
        res_t                  pending_results[$];
        int                    errors;
        int                    items;
        int                    rearms;
        int                    detections;

        function new();
            mode        = RST_DETECT_MODE;
            speed_thr   = RST_SPEED_THRESHOLD;
            confirm_lim = RST_CONFIRM_LIMIT;
            drop_thr    = RST_DROP_THRESHOLD;
            errors      = 0;
            items       = 0;
            rearms      = 0;
            detections  = 0;
            clear_tracking();
        endfunction

        function void clear_tracking();
            last_sample   = '0;
            floor_sample  = '0;
            run_count     = '0;
            floor_valid   = 1'b0;
            start_latched = 1'b0;
        endfunction

        // Difference a - b wrapped to the sample width, read as signed.
        function int signed_gap(logic [PRESSURE_W-1:0] a, logic [PRESSURE_W-1:0] b);
            logic [PRESSURE_W-1:0] d;
            d = a - b;
            return d[PRESSURE_W-1] ? int'(d) - (1 << PRESSURE_W) : int'(d);
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_DETECT_MODE:     mode        = d[0];
                REG_SPEED_THRESHOLD: speed_thr   = d[THR_W-1:0];
                REG_CONFIRM_LIMIT:   confirm_lim = d[LIMIT_W-1:0];
                REG_DROP_THRESHOLD:  drop_thr    = d[THR_W-1:0];
                default:             ;
            endcase
        endfunction

        // Note an accepted sample transfer and queue the result it must produce.
        function void take_item(logic f, logic [PRESSURE_W-1:0] p);
            res_t exp_res;
            int   gap;
            logic fired;
            fired   = 1'b0;
            exp_res = '0;
            items++;
            if (f == FUNC_REARM) begin
                rearms++;
                clear_tracking();
            end
            else if (!start_latched && p != '0) begin
                if (mode == MODE_SPEED) begin
                    if (last_sample == '0) begin
                        last_sample = p;
                    end
                    else begin
                        gap = signed_gap(p, last_sample);
                        last_sample = p;
                        if (gap > int'(speed_thr)) begin
                            run_count = run_count + 8'd1;
                            fired = (run_count >= confirm_lim);
                        end
                        else begin
                            run_count = '0;
                        end
                    end
                end
                else begin
                    if (!floor_valid) begin
                        floor_sample = p;
                        floor_valid  = 1'b1;
                    end
                    else begin
                        if (signed_gap(p, floor_sample) < 0)
                            floor_sample = p;
                        gap = signed_gap(p, floor_sample);
                        fired = (gap > int'(drop_thr));
                    end
                end
                if (fired) begin
                    start_latched  = 1'b1;
                    detections++;
                    exp_res.trigger_amount = (gap > int'(AMOUNT_MAX)) ? AMOUNT_MAX
                                                                      : gap[AMOUNT_W-1:0];
                end
            end
            exp_res.started   = start_latched;
            exp_res.fired_now = fired;
            pending_results.push_back(exp_res);
        endfunction

        // Compare one result transfer against the oldest queued expectation.
        function void check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0) begin
                $error("result transfer with no sample outstanding: %p", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.started !== want.started) begin
                $error("started: expected %0d, got %0d", want.started, got.started);
                errors++;
            end
            if (got.fired_now !== want.fired_now) begin
                $error("fired_now: expected %0d, got %0d", want.fired_now, got.fired_now);
                errors++;
            end
            if (got.trigger_amount !== want.trigger_amount) begin
                $error("trigger_amount: expected %0d, got %0d",
                       want.trigger_amount, got.trigger_amount);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic quiet;
    int   reg_writes;
    logic [PRESSURE_W-1:0] level;

    start_tracker tracker = new();

    psd_in_if  sample_ch ();
    psd_out_if result_ch ();
    psd_cfg_if cfg_ch ();

    pressure_start_detector u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side back-pressure, changed at the falling edge.
    always @(negedge clk)
    begin
        result_ch.ready = quiet || ($urandom_range(99) >= 25);
    end

    // Every result transfer goes to the checker.
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got.started        = result_ch.started;
            got.fired_now      = result_ch.fired_now;
            got.trigger_amount = result_ch.trigger_amount;
            tracker.check_result(got);
        end
    end

    // Drive one sample transfer; entered and left at a falling edge.
    task automatic send_item(logic f, logic [PRESSURE_W-1:0] p);
        while (!quiet && $urandom_range(99) < 25) begin
            sample_ch.valid    = 1'b0;
            sample_ch.pressure = PRESSURE_W'($urandom());
            @(negedge clk);
        end
        sample_ch.valid    = 1'b1;
        sample_ch.func     = f;
        sample_ch.pressure = p;
        do @(posedge clk); while (!sample_ch.ready);
        tracker.take_item(f, p);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = d;
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.apply_write(idx, d);
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic wait_idle();
        sample_ch.valid = 1'b0;
        while (tracker.pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Threshold value with a bias toward small settings and both extremes.
    function automatic logic [THR_W-1:0] pick_threshold(int typical);
        case ($urandom_range(9))
            0:       return '0;
            1:       return AMOUNT_MAX;
            default: return THR_W'($urandom_range(0, typical));
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return LIMIT_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Pressure step sized from the active threshold (a sixth of it in drop mode), mostly just above that size.
    function automatic int next_step();
        int thr;
        if (tracker.mode == MODE_SPEED)
            thr = int'(tracker.speed_thr);
        else
            thr = int'(tracker.drop_thr) / 6 + 1;
        case ($urandom_range(9))
            0:       return -int'($urandom_range(0, 2 * thr + 2));
            1, 2:    return int'($urandom_range(0, 2 * thr + 4)) - (thr + 2);
            default: return thr + int'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic configure_phase(int phase);
        logic [CFG_DATA_W-1:0] noise;
        noise = $urandom();
        write_reg(REG_DETECT_MODE, {noise[CFG_DATA_W-1:1], 1'($urandom_range(1))});
        if (phase == 0 || $urandom_range(1))
            write_reg(REG_SPEED_THRESHOLD, (noise << THR_W) | pick_threshold(20));
        if (phase == 0 || $urandom_range(1))
            write_reg(REG_CONFIRM_LIMIT, (noise << LIMIT_W) | pick_limit());
        if (phase == 0 || $urandom_range(1))
            write_reg(REG_DROP_THRESHOLD, (noise << THR_W) | pick_threshold(100));
        if ($urandom_range(7) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 255)), $urandom());
    endtask

    // Main stimulus.
    initial
    begin
        int phase;
        int len;
        int pick;

        rst_n              = 1'b0;
        quiet              = 1'b0;
        reg_writes         = 0;
        level              = 16'd2000;
        sample_ch.valid    = 1'b0;
        sample_ch.func     = FUNC_SAMPLE;
        sample_ch.pressure = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        result_ch.ready    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drop mode at reset settings: zero sample, seeding, base tracking,
        // threshold edge, detection, latched samples, wrapped compares, amount at the saturation limit.
        send_item(FUNC_SAMPLE, 16'd0);
        send_item(FUNC_SAMPLE, 16'd1000);
        send_item(FUNC_SAMPLE, 16'd990);
        send_item(FUNC_SAMPLE, 16'd1030);
        send_item(FUNC_SAMPLE, 16'd1031);
        send_item(FUNC_SAMPLE, 16'd0);
        send_item(FUNC_SAMPLE, 16'd7);
        send_item(FUNC_REARM, 16'hffff);
        send_item(FUNC_SAMPLE, 16'hffff);
        send_item(FUNC_SAMPLE, 16'h8000);
        send_item(FUNC_SAMPLE, 16'h0001);
        send_item(FUNC_SAMPLE, 16'h8000);
        send_item(FUNC_REARM, 16'h0000);
        send_item(FUNC_SAMPLE, 16'd500);

        // Switch to speed mode with the drop base still seeded.
        wait_idle();
        write_reg(REG_DETECT_MODE, 32'hffff_fffe | MODE_SPEED);
        write_reg(8'hff, 32'h1234_5678);
        send_item(FUNC_SAMPLE, 16'd100);
        send_item(FUNC_SAMPLE, 16'd105);
        send_item(FUNC_SAMPLE, 16'd110);
        send_item(FUNC_SAMPLE, 16'd114);
        send_item(FUNC_SAMPLE, 16'd120);
        send_item(FUNC_SAMPLE, 16'd126);
        send_item(FUNC_SAMPLE, 16'd132);
        send_item(FUNC_REARM, 16'd0);

        // Confirm limit of zero: the first exceeding delta fires.
        wait_idle();
        write_reg(REG_CONFIRM_LIMIT, 32'hffff_ff00);
        write_reg(REG_SPEED_THRESHOLD, 32'hffff_8000);
        send_item(FUNC_SAMPLE, 16'd50);
        send_item(FUNC_SAMPLE, 16'd50);
        send_item(FUNC_SAMPLE, 16'd52);

        // Random phases of ramps with noise, rearms and register changes.
        phase = 0;
        while (tracker.items < ITEM_TOTAL) begin
            wait_idle();
            configure_phase(phase);
            quiet = (phase == 3 || phase == 4);
            len = $urandom_range(100, 145);
            if (len > ITEM_TOTAL - tracker.items)
                len = ITEM_TOTAL - tracker.items;
            for (int n = 0; n < len; n++) begin
                pick = $urandom_range(99);
                if (tracker.start_latched ? pick < 40 : pick < 2) begin
                    send_item(FUNC_REARM, PRESSURE_W'($urandom()));
                end
                else if (pick < 45 && tracker.start_latched) begin
                    send_item(FUNC_SAMPLE, PRESSURE_W'($urandom()));
                end
                else if (pick < 5) begin
                    send_item(FUNC_SAMPLE, '0);
                end
                else if (pick < 9) begin
                    level = PRESSURE_W'($urandom());
                    send_item(FUNC_SAMPLE, level);
                end
                else begin
                    level = level + PRESSURE_W'(next_step());
                    send_item(FUNC_SAMPLE, level);
                end
            end
            phase++;
        end
        quiet = 1'b0;

        wait_idle();
        repeat (10) @(negedge clk);
        $display("Run covered %0d items (%0d rearms, %0d detections) in %0d random phases,",
                 tracker.items, tracker.rearms, tracker.detections, phase);
        $display("with %0d register writes across both detection modes.", reg_writes);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog in case the handshakes hang.
    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
